FILE: rtl/slcd_pkg.sv
package slcd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  SYNC_RESET   = 8'hAA;
    localparam logic [15:0] MAXLEN_RESET = 16'd256;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    // result kinds on m_tuser
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_CRC_BAD = 2'd2;
    localparam logic [1:0] KIND_LEN_ERR = 2'd3;

    // commands from the parser to the back end
    localparam logic [1:0] OP_PAYLOAD = 2'd0;
    localparam logic [1:0] OP_CHECK   = 2'd1;
    localparam logic [1:0] OP_LEN_ERR = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic [15:0] length;
        logic [15:0] rcrc;
    } slcd_cmd_t;

    typedef struct packed {
        logic [7:0]  sync_byte;
        logic [15:0] max_payload_len;
    } slcd_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } slcd_qstat_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc,
                                                   input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/slcd_front.sv
module slcd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  slcd_pkg::slcd_cfg_t cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  slcd_pkg::slcd_qstat_t qstat,
    output logic                push,
    output slcd_pkg::slcd_cmd_t cmd
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC_HI  = 3'd4;
    localparam logic [2:0] PH_CRC_LO  = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic        accept;
    logic [15:0] len_full;
    logic [15:0] count_plus;

    assign in_ready   = !qstat.full;
    assign accept     = in_valid && in_ready;
    assign len_full   = {length_reg[15:8], in_byte};
    assign count_plus = count_reg + 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        crc_hi_next = crc_hi_reg;
        push        = 1'b0;
        cmd         = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_LEN_HI:
                begin
                    length_next = {in_byte, 8'h00};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = len_full;
                    count_next  = 16'd0;
                    if (len_full > cfg.max_payload_len)
                    begin
                        push       = 1'b1;
                        cmd.op     = slcd_pkg::OP_LEN_ERR;
                        cmd.length = len_full;
                        phase_next = PH_HUNT;
                    end
                    else if (len_full == 16'd0)
                        phase_next = PH_CRC_HI;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    count_next = count_plus;
                    if (count_plus >= length_reg)
                        phase_next = PH_CRC_HI;
                    push     = 1'b1;
                    cmd.op   = slcd_pkg::OP_PAYLOAD;
                    cmd.data = in_byte;
                end
                PH_CRC_HI:
                begin
                    crc_hi_next = in_byte;
                    phase_next  = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    push       = 1'b1;
                    cmd.op     = slcd_pkg::OP_CHECK;
                    cmd.length = length_reg;
                    cmd.rcrc   = {crc_hi_reg, in_byte};
                    count_next = 16'd0;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    // hunting; stray codes behave the same
                    if (in_byte == cfg.sync_byte)
                    begin
                        phase_next = PH_LEN_HI;
                        count_next = 16'd0;
                    end
                    else
                        phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            length_reg <= 16'd0;
            count_reg  <= 16'd0;
            crc_hi_reg <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

endmodule

FILE: rtl/slcd_queue.sv
module slcd_queue #(
    parameter int DEPTH = slcd_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  slcd_pkg::slcd_cmd_t   wr_cmd,
    input  logic                  pop,
    output slcd_pkg::slcd_cmd_t   rd_cmd,
    output slcd_pkg::slcd_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    slcd_pkg::slcd_cmd_t entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);
    assign rd_cmd      = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/slcd_back.sv
module slcd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slcd_pkg::slcd_cmd_t   cmd,
    input  slcd_pkg::slcd_qstat_t qstat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_kind,
    output logic [55:0]           out_data
);

    logic [15:0] crc_reg, crc_next;
    logic        valid_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [55:0] data_reg, data_next;
    logic [15:0] crc_upd;

    assign pop       = !qstat.empty && (!valid_reg || out_ready);
    assign crc_upd   = slcd_pkg::crc16_add_byte(crc_reg, cmd.data);
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;

    // data layout: computed_crc, received_crc, frame_length, payload_byte
    always_comb
    begin
        crc_next  = crc_reg;
        kind_next = slcd_pkg::KIND_PAYLOAD;
        data_next = '0;
        case (cmd.op)
            slcd_pkg::OP_PAYLOAD:
            begin
                crc_next  = crc_upd;
                kind_next = slcd_pkg::KIND_PAYLOAD;
                data_next = {48'd0, cmd.data};
            end
            slcd_pkg::OP_CHECK:
            begin
                crc_next  = slcd_pkg::CRC_INIT;
                kind_next = (cmd.rcrc == crc_reg) ? slcd_pkg::KIND_GOOD
                                                  : slcd_pkg::KIND_CRC_BAD;
                data_next = {crc_reg, cmd.rcrc, cmd.length, 8'd0};
            end
            default:
            begin
                crc_next  = slcd_pkg::CRC_INIT;
                kind_next = slcd_pkg::KIND_LEN_ERR;
                data_next = {32'd0, cmd.length, 8'd0};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= slcd_pkg::CRC_INIT;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                crc_reg   <= crc_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/sync_length_crc16_deframer_top.sv
// Frame receiver: sync byte, 16-bit big-endian length, payload, CRC-16 (CCITT-FALSE).
// Input stream: one link byte per transaction on s_tdata. Output stream: one
// result per transaction, kind on m_tuser (payload byte, frame good, CRC
// mismatch, length too large), fields on m_tdata. A frame with a bad verdict
// must be discarded by the receiver; its payload has already gone out.
// APB registers: 0x0 sync byte, 0x4 max payload length. Write only when idle.
// Throughput: one byte per cycle while the command queue has room. The parser
// classifies a byte in its cycle of arrival; the back end folds a payload byte
// into the CRC as it pops the command. Each result passes through the command
// queue and the output register, where a stalled m_tready can hold it.
// A stalled m_tready fills the command queue (QUEUE_DEPTH entries) plus the
// output register; s_tready drops only when the queue is full.
// Reset: parser hunts for sync, CRC at 0xFFFF, queue empty, registers to
// 0xAA and 256; no clearing pass is needed.
module sync_length_crc16_deframer_top #(
    parameter int QUEUE_DEPTH = slcd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] payload_byte, [23:8] frame_length,
                                   // [39:24] received_crc, [55:40] computed_crc
    output logic [1:0]  m_tuser    // [1:0] kind
);

    slcd_pkg::slcd_cfg_t   cfg_reg;
    slcd_pkg::slcd_cmd_t   push_cmd, pop_cmd;
    slcd_pkg::slcd_qstat_t qstat;
    logic                  push, pop;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte       <= slcd_pkg::SYNC_RESET;
            cfg_reg.max_payload_len <= slcd_pkg::MAXLEN_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2])
                cfg_reg.max_payload_len <= pwdata[15:0];
            else
                cfg_reg.sync_byte <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[1:0] != 2'b00)
            prdata = 32'd0;
        else if (paddr[2])
            prdata = {16'd0, cfg_reg.max_payload_len};
        else
            prdata = {24'd0, cfg_reg.sync_byte};
    end

    slcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .qstat    (qstat),
        .push     (push),
        .cmd      (push_cmd)
    );

    slcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (push_cmd),
        .pop    (pop),
        .rd_cmd (pop_cmd),
        .qstat  (qstat)
    );

    slcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pop_cmd),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_data  (m_tdata)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstat.empty))
        else $error("command queue underflow");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == slcd_pkg::KIND_PAYLOAD) |-> (m_tdata[55:8] == 48'd0))
        else $error("payload result carries verdict fields");

    a_len_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == slcd_pkg::KIND_LEN_ERR)
            |-> (m_tdata[55:24] == 32'd0 && m_tdata[7:0] == 8'd0))
        else $error("length error result carries CRC or payload fields");

endmodule

FILE: tb/sv/slcd_tb_pkg.sv
package slcd_tb_pkg;

    import slcd_pkg::*;

    // APB register map
    localparam logic [2:0] ADDR_SYNC   = 3'h0;
    localparam logic [2:0] ADDR_MAXLEN = 3'h4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pbyte;
        logic [15:0] flen;
        logic [15:0] rcrc;
        logic [15:0] ccrc;
    } deframe_result_t;

    // CCITT-FALSE update, MSB first, no reflection
    function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                     input logic [7:0] b);
        logic [15:0] acc;
        acc = crc;
        for (int k = 7; k >= 0; k--)
        begin
            if (acc[15] ^ b[k])
                acc = (acc << 1) ^ CRC_POLY;
            else
                acc = acc << 1;
        end
        return acc;
    endfunction

endpackage

FILE: tb/sv/slcd_frame_checker.sv
module slcd_frame_checker
    import slcd_pkg::*;
    import slcd_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // [7:0] payload_byte, [23:8] frame_length,
                                   // [39:24] received_crc, [55:40] computed_crc
    input  logic [1:0]  m_tuser,   // [1:0] kind
    output int          errors,
    output int          pending
);

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_LEN_HI,
        RX_LEN_LO,
        RX_PAYLOAD,
        RX_CRC_HI,
        RX_CRC_LO
    } rx_state_e;

    deframe_result_t expected_results[$];
    int              fails;

    logic [7:0]  sync_val;
    logic [15:0] max_len;
    rx_state_e   rx_state;
    logic [15:0] rx_len;
    logic [15:0] byte_count;
    logic [15:0] crc_acc;
    logic [7:0]  crc_hi;

    task automatic restart_hunt();
        rx_state   = RX_HUNT;
        byte_count = '0;
        crc_acc    = CRC_INIT;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        deframe_result_t r;
        r = '0;
        case (rx_state)
            RX_LEN_HI:
            begin
                rx_len   = {b, 8'h00};
                rx_state = RX_LEN_LO;
            end
            RX_LEN_LO:
            begin
                rx_len[7:0] = b;
                byte_count  = '0;
                crc_acc     = CRC_INIT;
                if (rx_len > max_len)
                begin
                    r.kind = KIND_LEN_ERR;
                    r.flen = rx_len;
                    expected_results.push_back(r);
                    restart_hunt();
                end
                else
                    rx_state = (rx_len == 16'd0) ? RX_CRC_HI : RX_PAYLOAD;
            end
            RX_PAYLOAD:
            begin
                crc_acc    = crc16_ccitt_byte(crc_acc, b);
                byte_count = byte_count + 16'd1;
                if (byte_count >= rx_len)
                    rx_state = RX_CRC_HI;
                r.kind  = KIND_PAYLOAD;
                r.pbyte = b;
                expected_results.push_back(r);
            end
            RX_CRC_HI:
            begin
                crc_hi   = b;
                rx_state = RX_CRC_LO;
            end
            RX_CRC_LO:
            begin
                r.rcrc = {crc_hi, b};
                r.kind = (r.rcrc == crc_acc) ? KIND_GOOD : KIND_CRC_BAD;
                r.flen = rx_len;
                r.ccrc = crc_acc;
                expected_results.push_back(r);
                restart_hunt();
            end
            default:
            begin
                // sync value only counts while hunting
                if (b == sync_val)
                begin
                    rx_state   = RX_LEN_HI;
                    byte_count = '0;
                    crc_acc    = CRC_INIT;
                end
                else
                    rx_state = RX_HUNT;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    // output side first: a transaction leaving now was predicted at an earlier edge
    always @(posedge clk or negedge rst_n)
    begin
        deframe_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            fails      = 0;
            sync_val   = SYNC_RESET;
            max_len    = MAXLEN_RESET;
            rx_len     = '0;
            crc_hi     = '0;
            restart_hunt();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d, data 0x%0h", m_tuser, m_tdata);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_tuser));
                    check_field("payload_byte", 16'(want.pbyte), 16'(m_tdata[7:0]));
                    check_field("frame_length", want.flen, m_tdata[23:8]);
                    check_field("received_crc", want.rcrc, m_tdata[39:24]);
                    check_field("computed_crc", want.ccrc, m_tdata[55:40]);
                end
            end
            if (s_tvalid && s_tready)
                predict_byte(s_tdata);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_SYNC:   sync_val = pwdata[7:0];
                    ADDR_MAXLEN: max_len  = pwdata[15:0];
                    default:     ;
                endcase
            end
            errors  <= fails;
            pending <= expected_results.size();
        end
    end

endmodule

FILE: tb/sv/sync_length_crc16_deframer_top_test.sv
module sync_length_crc16_deframer_top_test;

    import slcd_pkg::*;
    import slcd_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    int errors;
    int pending;
    int src_idle;
    int sink_idle;
    int frame_bytes;

    logic [7:0]  cur_sync;
    logic [15:0] cur_max;
    logic [7:0]  body[$];

    sync_length_crc16_deframer_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    slcd_frame_checker frame_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle);

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending and let every predicted result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SYNC)
            cur_sync = data[7:0];
        else
            cur_max = data[15:0];
    endtask

    task automatic send_header(input logic [15:0] len);
        push_byte(cur_sync);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        frame_bytes += 3;
    endtask

    // body may hold fewer bytes than len: the frame then runs into what follows
    task automatic send_frame(input logic [15:0] len, input bit bad_crc);
        logic [15:0] crc;
        crc = CRC_INIT;
        send_header(len);
        foreach (body[i])
        begin
            push_byte(body[i]);
            crc = crc16_ccitt_byte(crc, body[i]);
        end
        if (bad_crc)
            crc ^= 16'h0001 << $urandom_range(15);
        push_byte(crc[15:8]);
        push_byte(crc[7:0]);
        frame_bytes += body.size() + 2;
    endtask

    task automatic fill_body(input int n);
        body.delete();
        repeat (n) body.push_back(8'($urandom_range(255)));
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(4, 1))
        begin
            do
                b = 8'($urandom_range(255));
            while (b == cur_sync);
            push_byte(b);
        end
    endtask

    task automatic random_action();
        int pick;
        int lim;
        int len;
        pick = $urandom_range(99);
        lim  = (cur_max < 16'd12) ? int'(cur_max) : 12;
        if ($urandom_range(19) == 0)
            lim = (cur_max < 16'd64) ? int'(cur_max) : 64;
        len = $urandom_range(lim, 0);
        if ($urandom_range(99) == 0)
            drain();
        if (pick < 8)
            send_noise();
        else if (pick < 15 && cur_max != 16'hFFFF)
            send_header(16'($urandom_range(32'hFFFF, int'(cur_max) + 1)));
        else if (pick < 21 && cur_max <= 16'd300 && len > 0)
        begin
            fill_body(len - $urandom_range(len, 1));
            send_frame(16'(len), 1'b0);
        end
        else
        begin
            fill_body(len);
            send_frame(16'(len), pick < 32);
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        src_idle    = 28;
        sink_idle   = 50;
        frame_bytes = 0;
        cur_sync    = SYNC_RESET;
        cur_max     = MAXLEN_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        push_byte(8'h55);
        body = '{8'h00, 8'hFF};
        send_frame(16'd2, 1'b0);
        body = '{SYNC_RESET};
        send_frame(16'd1, 1'b1);
        body.delete();
        send_frame(16'd0, 1'b0);
        send_header(16'hFFFF);

        // zero max length: only empty frames pass
        drain();
        apb_write(ADDR_MAXLEN, 32'd0);
        send_frame(16'd0, 1'b0);
        send_header(16'd1);

        // sync change while a header is half received
        drain();
        push_byte(cur_sync);
        push_byte(8'h00);
        drain();
        apb_write(ADDR_SYNC, 32'h3C);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hFF);
        send_frame(16'd0, 1'b0);

        for (int ph = 0; ph < 3; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    apb_write(ADDR_SYNC, $urandom_range(255));
                    apb_write(ADDR_MAXLEN, $urandom_range(64, 8));
                end
                1:
                begin
                    src_idle  = 50;
                    sink_idle = 28;
                    apb_write(ADDR_SYNC, 32'h00);
                    apb_write(ADDR_MAXLEN, 32'hFFFF);
                end
                default:
                begin
                    src_idle  = 0;
                    sink_idle = 0;
                    apb_write(ADDR_SYNC, 32'hFF);
                    apb_write(ADDR_MAXLEN, $urandom_range(32'hFFFF));
                end
            endcase
            frame_bytes = 0;
            while (frame_bytes < 290)
                random_action();
        end

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #1_200_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
